[src/alist_pkg.sv]
package alist_pkg;

    // Field widths of the words on the two channels
    localparam int ACT_W    = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int FIDX_W   = 4;
    localparam int CNT_W    = 5;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS  = 2'd3;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // latch the incoming word and compare against the list
        logic exec;     // apply the action and load the result register
    } dp_cmd_t;

endpackage

[src/alist_if.sv]
// Request channel
interface alist_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [alist_pkg::ACT_W-1:0]           action;
    logic signed [alist_pkg::VAL_W-1:0]    value;
    logic [alist_pkg::POS_W-1:0]           position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

// Result channel
interface alist_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [alist_pkg::STAT_W-1:0]          status;
    logic                                  found;
    logic [alist_pkg::FIDX_W-1:0]          found_index;
    logic [alist_pkg::CNT_W-1:0]           count;

    modport source (output valid, output status, output found, output found_index,
                    output count, input ready);
    modport sink   (input valid, input status, input found, input found_index,
                    input count, output ready);
endinterface

[src/alist_ctrl.sv]
module alist_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output alist_pkg::dp_cmd_t cmd
);
    import alist_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    // Handshake decode
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd.load  = accept;
    assign cmd.exec  = (state_reg == S_EXEC) && out_free;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/alist_dp.sv]
module alist_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  alist_pkg::dp_cmd_t                    cmd,
    input  logic [alist_pkg::ACT_W-1:0]           action,
    input  logic signed [alist_pkg::VAL_W-1:0]    value,
    input  logic [alist_pkg::POS_W-1:0]           position,
    output logic [alist_pkg::STAT_W-1:0]          status,
    output logic                                  found,
    output logic [alist_pkg::FIDX_W-1:0]          found_index,
    output logic [alist_pkg::CNT_W-1:0]           count
);
    import alist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [VAL_W-1:0]   entry_reg [CAPACITY];
    logic [VAL_W-1:0]   entry_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    logic [ACT_W-1:0]   action_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CAPACITY-1:0] match_reg, match_next;

    logic [STAT_W-1:0]  status_reg, status_next;
    logic               found_reg, found_next;
    logic [FIDX_W-1:0]  fidx_reg, fidx_next;
    logic [CNT_W-1:0]   cnt_out_reg;

    logic [PW-1:0]      cnt_x, pos_x;
    logic               ins_ok, del_ok;
    logic [IW-1:0]      hit_idx;

    // Parallel compare of the incoming word against live entries
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            match_next[i] = (entry_reg[i] == value) && (CW'(i) < count_reg);
    end

    // Lowest matching index
    always_comb
    begin
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (match_reg[i])
                hit_idx = IW'(i);
    end

    // Action checks
    assign cnt_x  = PW'(count_reg);
    assign pos_x  = PW'(pos_reg);
    assign ins_ok = (action_reg == ACT_INSERT) && (count_reg != CW'(CAPACITY))
                    && (pos_x <= cnt_x);
    assign del_ok = (action_reg == ACT_DELETE) && (count_reg != '0) && (pos_x < cnt_x);

    // Result fields and new count
    always_comb
    begin
        status_next = STAT_OK;
        found_next  = 1'b0;
        fidx_next   = '0;
        count_next  = count_reg;
        case (action_reg)
            ACT_INSERT:
            begin
                if (count_reg == CW'(CAPACITY))
                    status_next = STAT_FULL;
                else if (!ins_ok)
                    status_next = STAT_BADPOS;
                else
                    count_next = count_reg + CW'(1);
            end
            ACT_DELETE:
            begin
                if (count_reg == '0)
                    status_next = STAT_EMPTY;
                else if (!del_ok)
                    status_next = STAT_BADPOS;
                else
                    count_next = count_reg - CW'(1);
            end
            ACT_SEARCH:
            begin
                found_next = |match_reg;
                fidx_next  = FIDX_W'(hit_idx);
            end
            default: ;
        endcase
    end

    // Shift network: insert moves entries up, delete moves them down
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            entry_next[i] = entry_reg[i];
        if (ins_ok)
        begin
            for (int i = 1; i < CAPACITY; i++)
                if (PW'(i) > pos_x)
                    entry_next[i] = entry_reg[i-1];
            for (int i = 0; i < CAPACITY; i++)
                if (PW'(i) == pos_x)
                    entry_next[i] = value_reg;
        end
        else if (del_ok)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
                if (PW'(i) >= pos_x)
                    entry_next[i] = entry_reg[i+1];
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    // Operand latch, entries and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            value_reg  <= value;
            pos_reg    <= position;
            match_reg  <= match_next;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                entry_reg[i] <= entry_next[i];
            status_reg  <= status_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
            cnt_out_reg <= CNT_W'(count_next);
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = fidx_reg;
    assign count       = cnt_out_reg;

endmodule

[src/array_list_insert_delete_search_unit.sv]
// Ordered list of up to CAPACITY signed 32-bit entries held in a register array.
// in_ch  : one word per action: action (insert, delete, search), value, position.
// out_ch : one word per action: status, found, found_index, count after action.
// Both channels use valid/ready; a word moves when both are high on a clock edge.
// When a request is taken, its value is compared against every entry at once
// and the match vector is latched; in the execute state the block applies the
// one-step shift of the array, picks the lowest matching index and loads the
// result register.
// One request is in flight at a time: a new request is not taken until the
// result of the last one is in its register.
// The request side is ready again once the result is in its register, so the
// next request is taken while that result still waits; if the receiver holds
// ready low the block stalls in its execute state until the register frees.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// result; entry contents are left as they were and are never read until
// rewritten.
module array_list_insert_delete_search_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    alist_in_if.sink    in_ch,
    alist_out_if.source out_ch
);
    import alist_pkg::*;

    dp_cmd_t cmd;

    alist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    alist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (in_ch.action),
        .value       (in_ch.value),
        .position    (in_ch.position),
        .status      (out_ch.status),
        .found       (out_ch.found),
        .found_index (out_ch.found_index),
        .count       (out_ch.count)
    );

endmodule

[src/alist_checker.sv]
module alist_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [alist_pkg::STAT_W-1:0]        status,
    input  logic                                found,
    input  logic [alist_pkg::FIDX_W-1:0]        found_index,
    input  logic [alist_pkg::CNT_W-1:0]         count
);
    import alist_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
        && $stable(found_index) && $stable(count))
        else $error("result word changed under stall");

    // One request in flight: no request taken right after another
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while one is in flight");

    // A hit only comes from a successful search
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STAT_OK)
        else $error("found set on a failed action");

    // Full and empty reports agree with the count
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> count == '0 && !found)
        else $error("empty reported with entries present");

endmodule

bind array_list_insert_delete_search_unit alist_checker #(
    .CAPACITY (CAPACITY)
) u_alist_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .found       (out_ch.found),
    .found_index (out_ch.found_index),
    .count       (out_ch.count)
);
